// ===== rtl/core/lbpu_pkg.sv =====
// shared types, constants and the uniform label table of the lbp window labeler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lbpu_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int PIX_W      = 8;
  localparam int LABEL_W    = 6;
  localparam int CODE_W     = 8;
  localparam int MIN_SIZE   = 3;

  localparam logic [LABEL_W-1:0] NON_UNIFORM = LABEL_W'(58);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_REGION_LEFT   = 3'd2,
    REG_REGION_TOP    = 3'd3,
    REG_REGION_WIDTH  = 3'd4,
    REG_REGION_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [9:0]         column;
    logic [9:0]         row;
  } lab_t;

  typedef struct packed {
    logic [SIZE_W-1:0] image_width;
    logic [SIZE_W-1:0] image_height;
    logic [9:0]        region_left;
    logic [9:0]        region_top;
    logic [SIZE_W-1:0] region_width;
    logic [SIZE_W-1:0] region_height;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } pos_t;

  typedef logic [255:0][LABEL_W-1:0] label_table_t;

  // codes with at most two circular transitions get ascending labels
  function automatic label_table_t build_label_table();
    label_table_t tab;
    logic [CODE_W-1:0] k;
    logic [CODE_W-1:0] diff;
    int n;
    int lab;
    lab = 0;
    for (int i = 0; i < 256; i++) begin
      k    = CODE_W'(i);
      diff = k ^ {k[CODE_W-2:0], k[CODE_W-1]};
      n    = $countones(diff);
      if (n <= 2) begin
        tab[i] = LABEL_W'(lab);
        lab++;
      end else begin
        tab[i] = NON_UNIFORM;
      end
    end
    return tab;
  endfunction

  localparam label_table_t LABEL_TABLE = build_label_table();

endpackage

`default_nettype wire

// ===== rtl/core/lbpu_scan.sv =====
// configuration registers and raster position counters
// depends on lbpu_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbpu_scan (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lbpu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lbpu_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                            accept,
  input  wire logic                            frame_start,
  output lbpu_pkg::cfg_t                       cfg,
  output lbpu_pkg::pos_t                       pos
);

  logic [lbpu_pkg::COL_W-1:0]  col_count;
  logic [lbpu_pkg::ROW_W-1:0]  row_count;
  logic [lbpu_pkg::SIZE_W-1:0] width_eff;
  logic [lbpu_pkg::SIZE_W-1:0] height_eff;
  logic [lbpu_pkg::COL_W-1:0]  col_start;
  logic [lbpu_pkg::ROW_W-1:0]  row_start;
  logic [lbpu_pkg::SIZE_W-1:0] col_inc;
  logic [lbpu_pkg::SIZE_W-1:0] row_inc;
  logic [lbpu_pkg::COL_W-1:0]  col_count_next;
  logic [lbpu_pkg::ROW_W-1:0]  row_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= lbpu_pkg::SIZE_W'(640);
      cfg.image_height  <= lbpu_pkg::SIZE_W'(480);
      cfg.region_left   <= '0;
      cfg.region_top    <= '0;
      cfg.region_width  <= lbpu_pkg::SIZE_W'(1024);
      cfg.region_height <= lbpu_pkg::SIZE_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        lbpu_pkg::REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data;
        lbpu_pkg::REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data;
        lbpu_pkg::REG_REGION_LEFT:   cfg.region_left   <= cfg_data[9:0];
        lbpu_pkg::REG_REGION_TOP:    cfg.region_top    <= cfg_data[9:0];
        lbpu_pkg::REG_REGION_WIDTH:  cfg.region_width  <= cfg_data;
        lbpu_pkg::REG_REGION_HEIGHT: cfg.region_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate image size
  always_comb begin
    if (cfg.image_width < lbpu_pkg::SIZE_W'(lbpu_pkg::MIN_SIZE)) begin
      width_eff = lbpu_pkg::SIZE_W'(lbpu_pkg::MIN_SIZE);
    end else if (cfg.image_width > lbpu_pkg::SIZE_W'(lbpu_pkg::MAX_WIDTH)) begin
      width_eff = lbpu_pkg::SIZE_W'(lbpu_pkg::MAX_WIDTH);
    end else begin
      width_eff = cfg.image_width;
    end
    if (cfg.image_height < lbpu_pkg::SIZE_W'(lbpu_pkg::MIN_SIZE)) begin
      height_eff = lbpu_pkg::SIZE_W'(lbpu_pkg::MIN_SIZE);
    end else if (cfg.image_height > lbpu_pkg::SIZE_W'(lbpu_pkg::MAX_HEIGHT)) begin
      height_eff = lbpu_pkg::SIZE_W'(lbpu_pkg::MAX_HEIGHT);
    end else begin
      height_eff = cfg.image_height;
    end
  end

  always_comb begin
    col_start = frame_start ? '0 : col_count;
    row_start = frame_start ? '0 : row_count;
    pos.col   = (lbpu_pkg::SIZE_W'(col_start) >= width_eff) ? '0 : col_start;
    pos.row   = (lbpu_pkg::SIZE_W'(row_start) >= height_eff) ? '0 : row_start;
    col_inc   = lbpu_pkg::SIZE_W'(pos.col) + lbpu_pkg::SIZE_W'(1);
    row_inc   = lbpu_pkg::SIZE_W'(pos.row) + lbpu_pkg::SIZE_W'(1);
    if (col_inc >= width_eff) begin
      col_count_next = '0;
      row_count_next = (row_inc >= height_eff) ? '0 : row_inc[lbpu_pkg::ROW_W-1:0];
    end else begin
      col_count_next = col_inc[lbpu_pkg::COL_W-1:0];
      row_count_next = pos.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lbpu_line_store.sv =====
// two line stores packed in one ram word, read-modify-write with forwarding
// depends on lbpu_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbpu_line_store (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          accept,
  input  wire lbpu_pkg::pos_t                pos,
  input  wire logic [lbpu_pkg::PIX_W-1:0]    pixel,
  output logic                               clearing,
  output logic                               s1_valid,
  output lbpu_pkg::pos_t                     s1_pos,
  output logic [lbpu_pkg::PIX_W-1:0]         s1_pixel,
  output logic [lbpu_pkg::PIX_W-1:0]         top,
  output logic [lbpu_pkg::PIX_W-1:0]         mid
);

  logic [2*lbpu_pkg::PIX_W-1:0] mem [lbpu_pkg::MAX_WIDTH];
  logic [2*lbpu_pkg::PIX_W-1:0] rd_data;
  logic [2*lbpu_pkg::PIX_W-1:0] fwd_pair;
  logic                         s1_fwd;
  logic [2*lbpu_pkg::PIX_W-1:0] wr_data;
  logic [lbpu_pkg::COL_W-1:0]   clr_addr;

  // older row in the upper byte
  always_comb begin
    {top, mid} = s1_fwd ? fwd_pair : rd_data;
    wr_data    = {mid, s1_pixel};
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (en && s1_valid) begin
      mem[s1_pos.col] <= wr_data;
    end
    if (accept) begin
      rd_data <= mem[pos.col];
    end
  end

  // one column zeroed per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + lbpu_pkg::COL_W'(1);
      if (clr_addr == lbpu_pkg::COL_W'(lbpu_pkg::MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos   <= pos;
      s1_pixel <= pixel;
      fwd_pair <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
      // same column written in this cycle, e.g. frame start right after column zero
      s1_fwd   <= accept && s1_valid && (s1_pos.col == pos.col);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lbpu_window.sv =====
// 3x3 window, region check and neighbour comparison
// depends on lbpu_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbpu_window (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire lbpu_pkg::cfg_t                cfg,
  input  wire logic                          s1_valid,
  input  wire lbpu_pkg::pos_t                s1_pos,
  input  wire logic [lbpu_pkg::PIX_W-1:0]    s1_pixel,
  input  wire logic [lbpu_pkg::PIX_W-1:0]    top,
  input  wire logic [lbpu_pkg::PIX_W-1:0]    mid,
  output logic                               s2_valid,
  output lbpu_pkg::pos_t                     s2_pos,
  output logic [lbpu_pkg::CODE_W-1:0]        code
);

  logic [lbpu_pkg::PIX_W-1:0] win [3][3];
  logic [lbpu_pkg::COL_W-1:0] cx;
  logic [lbpu_pkg::ROW_W-1:0] cy;
  logic [lbpu_pkg::COL_W-1:0] cx_off;
  logic [lbpu_pkg::ROW_W-1:0] cy_off;
  logic                       emit;
  logic [lbpu_pkg::PIX_W-1:0] ctr;

  always_comb begin
    cx     = s1_pos.col - lbpu_pkg::COL_W'(1);
    cy     = s1_pos.row - lbpu_pkg::ROW_W'(1);
    cx_off = cx - cfg.region_left;
    cy_off = cy - cfg.region_top;
    emit   = (s1_pos.col >= lbpu_pkg::COL_W'(2)) && (s1_pos.row >= lbpu_pkg::ROW_W'(2))
          && (cx >= cfg.region_left)
          && (lbpu_pkg::SIZE_W'(cx_off) < cfg.region_width)
          && (cy >= cfg.region_top)
          && (lbpu_pkg::SIZE_W'(cy_off) < cfg.region_height);
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= top;
      win[1][2] <= mid;
      win[2][2] <= s1_pixel;
      s2_pos.col <= cx;
      s2_pos.row <= cy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && emit;
    end
  end

  // neighbour weights in raster order, centre left out
  always_comb begin
    ctr     = win[1][1];
    code[0] = ctr < win[0][0];
    code[1] = ctr < win[0][1];
    code[2] = ctr < win[0][2];
    code[3] = ctr < win[1][0];
    code[4] = ctr < win[1][2];
    code[5] = ctr < win[2][0];
    code[6] = ctr < win[2][1];
    code[7] = ctr < win[2][2];
  end

endmodule

`default_nettype wire

// ===== rtl/core/lbpu_label.sv =====
// uniform label lookup and output register
// depends on lbpu_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbpu_label (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          s2_valid,
  input  wire lbpu_pkg::pos_t                s2_pos,
  input  wire logic [lbpu_pkg::CODE_W-1:0]   code,
  output logic                               lab_valid,
  output lbpu_pkg::lab_t                     lab
);

  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      lab.label  <= lbpu_pkg::LABEL_TABLE[code];
      lab.column <= s2_pos.col;
      lab.row    <= s2_pos.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lab_valid <= 1'b0;
    end else if (en) begin
      lab_valid <= s2_valid;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/uniform_lbp_window_labeler_top.sv =====
// channel   | direction | payload         | handshake
// pix       | in        | lbpu_pkg::pix_t | pix_valid / pix_stall
// lab       | out       | lbpu_pkg::lab_t | lab_valid / lab_stall
// cfg       | in        | cfg_data        | cfg_we, cfg_index
//
// one pixel per clock while pix_stall is low; a label follows its completing pixel transfer
// through the line-store ram read, window compare and table lookup into the output register
// the line-store ram reads and writes back one column per pixel, with forwarding
// after reset a clearing pass zeroes all 1024 columns of the line stores, pixel input stalled
// a stalled output holds the whole pipeline and stalls the pixel input
// top level of the uniform lbp window labeler, depends on lbpu_pkg and its submodules
`timescale 1ns / 1ps
`default_nettype none

module uniform_lbp_window_labeler_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            pix_valid,
  output logic                                 pix_stall,
  input  wire lbpu_pkg::pix_t                  pix,
  output logic                                 lab_valid,
  input  wire logic                            lab_stall,
  output lbpu_pkg::lab_t                       lab,
  input  wire logic                            cfg_we,
  input  wire logic [lbpu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lbpu_pkg::CFG_W-1:0]      cfg_data
);

  logic                               en;
  logic                               accept;
  logic                               clearing;
  lbpu_pkg::cfg_t                     cfg;
  lbpu_pkg::pos_t                     pos;
  logic                               s1_valid;
  lbpu_pkg::pos_t                     s1_pos;
  logic [lbpu_pkg::PIX_W-1:0]         s1_pixel;
  logic [lbpu_pkg::PIX_W-1:0]         top;
  logic [lbpu_pkg::PIX_W-1:0]         mid;
  logic                               s2_valid;
  lbpu_pkg::pos_t                     s2_pos;
  logic [lbpu_pkg::CODE_W-1:0]        code;

  assign en        = !(lab_valid && lab_stall);
  assign pix_stall = !en || clearing;
  assign accept    = pix_valid && !pix_stall;

  lbpu_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .frame_start (pix.frame_start),
    .cfg         (cfg),
    .pos         (pos)
  );

  lbpu_line_store u_line_store (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .accept   (accept),
    .pos      (pos),
    .pixel    (pix.pixel),
    .clearing (clearing),
    .s1_valid (s1_valid),
    .s1_pos   (s1_pos),
    .s1_pixel (s1_pixel),
    .top      (top),
    .mid      (mid)
  );

  lbpu_window u_window (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_pos   (s1_pos),
    .s1_pixel (s1_pixel),
    .top      (top),
    .mid      (mid),
    .s2_valid (s2_valid),
    .s2_pos   (s2_pos),
    .code     (code)
  );

  lbpu_label u_label (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .s2_valid  (s2_valid),
    .s2_pos    (s2_pos),
    .code      (code),
    .lab_valid (lab_valid),
    .lab       (lab)
  );

`ifndef NO_ASSERTIONS
  // centres in column zero or row zero never produce a label
  a_no_border: assert property (@(posedge clk) disable iff (rst)
    lab_valid |-> (lab.column != '0) && (lab.row != '0))
    else $error("label transfer for a border centre");

  a_label_range: assert property (@(posedge clk) disable iff (rst)
    lab_valid |-> (lab.label <= lbpu_pkg::NON_UNIFORM))
    else $error("label out of range");

  // a pixel still in the ram stage is not lost while the output is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !en) |=> s1_valid && $stable(s1_pos))
    else $error("line store stage dropped a pixel under stall");

  a_reset_quiet: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !lab_valid && !s1_valid && !s2_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the uniform lbp window labeler: directed test card, random frames and pressure
// labels are checked against an in-bench model of the line stores, window and label table
// depends on lbpu_pkg and uniform_lbp_window_labeler_top
`timescale 1ns / 1ps

module tb;
  import lbpu_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  pix_t                 pix = '0;
  logic                 lab_valid;
  logic                 lab_stall = 1'b0;
  lab_t                 lab;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  uniform_lbp_window_labeler_top dut (.*);

  always #2 clk = ~clk;

  // model of the block
  logic [LABEL_W-1:0] uni_label [256];
  logic [PIX_W-1:0]   line_above [MAX_WIDTH];
  logic [PIX_W-1:0]   line_two_up [MAX_WIDTH];
  logic [PIX_W-1:0]   win [3][3];
  int                 col_pos, row_pos;
  int                 img_w, img_h, reg_left, reg_top, reg_w, reg_h;

  pix_t pixels_pending [$];
  lab_t labels_due [$];
  lab_t oldest;
  int   n_offered = 0;
  int   n_taken = 0;
  int   errors = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   long_hold = 0;
  bit   hold_ask = 1'b0;
  bit   quiet = 1'b0;
  bit   burst = 1'b0;

  function automatic int clamp_dim(int v, int top);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int idle_len(bit off);
    int r;
    if (off) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic label_pixel(input pix_t p);
    int               w, h, cx, cy;
    logic [PIX_W-1:0] top, mid, ctr;
    logic [CODE_W-1:0] code;
    lab_t             e;
    w = clamp_dim(img_w, MAX_WIDTH);
    h = clamp_dim(img_h, MAX_HEIGHT);
    if (p.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    top = line_two_up[col_pos];
    mid = line_above[col_pos];
    line_two_up[col_pos] = mid;
    line_above[col_pos] = p.pixel;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = p.pixel;
    if (row_pos >= 2 && col_pos >= 2) begin
      cx = col_pos - 1;
      cy = row_pos - 1;
      if (cx >= reg_left && cx - reg_left < reg_w && cy >= reg_top && cy - reg_top < reg_h) begin
        ctr = win[1][1];
        // neighbours in raster order, top-left in the lsb
        code = {ctr < win[2][2], ctr < win[2][1], ctr < win[2][0], ctr < win[1][2],
                ctr < win[1][0], ctr < win[0][2], ctr < win[0][1], ctr < win[0][0]};
        e.label  = uni_label[code];
        e.column = 10'(cx);
        e.row    = 10'(cy);
        labels_due.push_back(e);
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // pixel driver
  always @(negedge clk) begin
    if (n_taken == n_offered) begin
      if (send_gap > 0) begin
        pix_valid <= 1'b0;
        send_gap--;
      end else if (pixels_pending.size() != 0) begin
        pix <= pixels_pending.pop_front();
        pix_valid <= 1'b1;
        n_offered++;
        send_gap = idle_len(quiet || burst);
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // label receiver
  always @(negedge clk) begin
    if (hold_ask) begin
      long_hold = 300;
      hold_ask = 1'b0;
    end
    if (long_hold > 0) begin
      lab_stall <= 1'b1;
      long_hold--;
    end else if (recv_gap > 0) begin
      lab_stall <= 1'b1;
      recv_gap--;
    end else begin
      lab_stall <= 1'b0;
      recv_gap = idle_len(quiet);
    end
  end

  // transfer monitor on both channels
  always @(posedge clk) begin
    if (!rst && pix_valid && !pix_stall) begin
      label_pixel(pix);
      n_taken++;
    end
    if (!rst && lab_valid && !lab_stall) begin
      if (labels_due.size() == 0) begin
        $display("%0t: unexpected label %0d at column %0d row %0d",
                 $time, lab.label, lab.column, lab.row);
        errors++;
      end else begin
        oldest = labels_due.pop_front();
        if (lab.label !== oldest.label) begin
          $display("%0t: label expected %0d got %0d", $time, oldest.label, lab.label);
          errors++;
        end
        if (lab.column !== oldest.column) begin
          $display("%0t: column expected %0d got %0d", $time, oldest.column, lab.column);
          errors++;
        end
        if (lab.row !== oldest.row) begin
          $display("%0t: row expected %0d got %0d", $time, oldest.row, lab.row);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_IMAGE_WIDTH:   img_w = int'(val);
      REG_IMAGE_HEIGHT:  img_h = int'(val);
      REG_REGION_LEFT:   reg_left = int'(val[9:0]);
      REG_REGION_TOP:    reg_top = int'(val[9:0]);
      REG_REGION_WIDTH:  reg_w = int'(val);
      REG_REGION_HEIGHT: reg_h = int'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_px(input logic [PIX_W-1:0] v, input bit fs);
    pix_t p;
    p.pixel = v;
    p.frame_start = fs;
    pixels_pending.push_back(p);
  endtask

  task automatic wait_drained();
    while (pixels_pending.size() != 0 || n_offered != n_taken || labels_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (12) @(negedge clk);
  endtask

  // tidy streams mark each frame start, noisy ones scatter frame_start at random
  task automatic fill_frames(input int n, input int style, input bit tidy);
    int               frame;
    logic [PIX_W-1:0] v;
    bit               fs;
    frame = clamp_dim(img_w, MAX_WIDTH) * clamp_dim(img_h, MAX_HEIGHT);
    for (int k = 0; k < n; k++) begin
      case (style)
        0: v = 8'($urandom_range(0, 255));
        1: v = 8'($urandom_range(0, 3));
        2: v = 8'((k * 5) + $urandom_range(0, 2));
        default: v = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      endcase
      fs = tidy ? (k % frame == 0) : ($urandom_range(0, 15) == 0);
      push_px(v, fs);
    end
  endtask

  initial begin
    int          flips, next_lab, n;
    int          w, h, rl, rt, rw, rh;
    byte unsigned card [25];

    next_lab = 0;
    for (int c = 0; c < 256; c++) begin
      flips = 0;
      for (int b = 0; b < 8; b++)
        if (((c >> b) & 1) != ((c >> ((b + 1) % 8)) & 1)) flips++;
      if (flips <= 2) begin
        uni_label[c] = LABEL_W'(next_lab);
        next_lab++;
      end else begin
        uni_label[c] = NON_UNIFORM;
      end
    end
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_above[i] = '0;
      line_two_up[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    col_pos = 0;
    row_pos = 0;
    img_w = 640;
    img_h = 480;
    reg_left = 0;
    reg_top = 0;
    reg_w = 1024;
    reg_h = 1024;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // test card on a 5x4 image: centre darker than all, at least as bright as all, ties,
    // then a wrap into the next frame and a restart in mid row
    write_reg(REG_IMAGE_WIDTH, 11'd5);
    write_reg(REG_IMAGE_HEIGHT, 11'd4);
    card = '{200, 1, 255, 0, 7,
             9, 0, 128, 128, 255,
             255, 3, 255, 0, 128,
             0, 255, 128, 255, 0,
             17, 34, 51, 68, 85};
    for (int k = 0; k < 25; k++) push_px(card[k], k == 0 || k == 23);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph % 4 == 2);
      w  = $urandom_range(3, 12);
      h  = $urandom_range(3, 9);
      rl = 0;
      rt = 0;
      rw = 1024;
      rh = 1024;
      if ($urandom_range(0, 1)) begin
        rl = $urandom_range(0, 5);
        rt = $urandom_range(0, 5);
        rw = $urandom_range(0, 10);
        rh = $urandom_range(0, 10);
      end
      case (ph)
        0: begin
          w = 0;
          h = 2;
        end
        1: begin
          w = 1;
          h = 0;
          rw = 2047;
          rh = 2047;
        end
        2: begin
          rl = 1023;
          rt = 1023;
        end
        5: begin
          w  = $urandom_range(0, 2047);
          h  = $urandom_range(0, 2047);
          rl = $urandom_range(0, 2047);
          rt = $urandom_range(0, 2047);
          rw = $urandom_range(0, 2047);
          rh = $urandom_range(0, 2047);
        end
        6: begin
          rl = 0;
          rt = 0;
          rw = 1024;
          rh = 1024;
        end
        default: ;
      endcase
      write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
      write_reg(REG_REGION_LEFT, CFG_W'(rl));
      write_reg(REG_REGION_TOP, CFG_W'(rt));
      write_reg(REG_REGION_WIDTH, CFG_W'(rw));
      write_reg(REG_REGION_HEIGHT, CFG_W'(rh));
      n = $urandom_range(45, 85);
      if (ph == 6) begin
        // receiver holds off while pixels keep coming
        burst = 1'b1;
        hold_ask = 1'b1;
        fill_frames(n, $urandom_range(0, 3), 1'b1);
      end else if (ph == 8) begin
        fill_frames(n / 2, 2, 1'b1);
        wait_drained();
        fill_frames(n - n / 2, 0, 1'b0);
      end else begin
        fill_frames(n, $urandom_range(0, 3), ph % 3 != 1);
      end
      wait_idle();
      burst = 1'b0;
    end

    // sixteen-column image, three labels at the far right of row one
    quiet = 1'b0;
    write_reg(REG_IMAGE_WIDTH, 11'd16);
    write_reg(REG_IMAGE_HEIGHT, 11'd2047);
    write_reg(REG_REGION_LEFT, 11'd12);
    write_reg(REG_REGION_TOP, 11'd1);
    write_reg(REG_REGION_WIDTH, 11'd2047);
    write_reg(REG_REGION_HEIGHT, 11'd1023);
    fill_frames(3 * 16, 0, 1'b1);
    wait_idle();

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lbpu_pkg.sv
rtl/core/lbpu_scan.sv
rtl/core/lbpu_line_store.sv
rtl/core/lbpu_window.sv
rtl/core/lbpu_label.sv
rtl/core/uniform_lbp_window_labeler_top.sv
sim/tb.sv
